>>> sv/sdtm_pkg.sv
// Shared types, codes and reset constants for the three-mode switch debouncer.
package sdtm_pkg;

    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned PIN_W      = 3;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [INTERVAL_W-1:0] RESET_INTERVAL_MS = 16'd10;

    // Debounce mode codes; the unused code falls back to stable interval
    localparam logic [MODE_W-1:0] MODE_STABLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCKOUT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROMPT  = 2'd2;

    // Opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_ATTACH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIN      = 2'd2;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval_ms;
        logic [MODE_W-1:0]     debounce_mode;
        logic [PIN_W-1:0]      pin_select;
    } cfg_t;

    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] port_sample;
        logic [TIME_W-1:0]   now_ms;
    } item_t;

    typedef struct packed {
        logic level;
        logic changed;
        logic rising;
        logic falling;
    } result_t;

endpackage

>>> sv/sdtm_cfg_regs.sv
// Configuration register file: interval, mode and pin select.
module sdtm_cfg_regs
    import sdtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_INTERVAL: cfg_next.interval_ms   = wr_data[INTERVAL_W-1:0];
                REG_MODE:     cfg_next.debounce_mode = wr_data[MODE_W-1:0];
                REG_PIN:      cfg_next.pin_select    = wr_data[PIN_W-1:0];
                default:      cfg_next = cfg_reg; // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_ms   <= RESET_INTERVAL_MS;
            cfg_reg.debounce_mode <= MODE_STABLE;
            cfg_reg.pin_select    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/sdtm_core.sv
// Debounce state registers and the single-pass next-state logic.
module sdtm_core
    import sdtm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic              stable_reg, stable_next;
    logic              raw_reg, raw_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              change_next;
    logic              pin_bit;
    logic [TIME_W-1:0] elapsed;
    logic              expired;

    assign pin_bit = item.port_sample[cfg.pin_select];
    // Wrapping subtraction, unsigned compare
    assign elapsed = item.now_ms - last_time_reg;
    assign expired = elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.interval_ms};

    always_comb
    begin
        stable_next    = stable_reg;
        raw_next       = raw_reg;
        last_time_next = last_time_reg;
        change_next    = 1'b0;
        if (item.opcode == OP_ATTACH)
        begin
            stable_next    = pin_bit;
            raw_next       = pin_bit;
            last_time_next = (cfg.debounce_mode == MODE_LOCKOUT) ? '0 : item.now_ms;
        end
        else
        begin
            case (cfg.debounce_mode)
                MODE_LOCKOUT:
                begin
                    if (expired && (pin_bit != stable_reg))
                    begin
                        stable_next    = ~stable_reg;
                        last_time_next = item.now_ms;
                        change_next    = 1'b1;
                    end
                end
                MODE_PROMPT:
                begin
                    // accept at once after a quiet interval, then track raw edges
                    if (expired && (pin_bit != stable_reg))
                    begin
                        stable_next = ~stable_reg;
                        change_next = 1'b1;
                    end
                    if (pin_bit != raw_reg)
                    begin
                        raw_next       = ~raw_reg;
                        last_time_next = item.now_ms;
                    end
                end
                default:
                begin
                    if (pin_bit != raw_reg)
                    begin
                        raw_next       = ~raw_reg;
                        last_time_next = item.now_ms;
                    end
                    else if (expired && (pin_bit != stable_reg))
                    begin
                        stable_next    = ~stable_reg;
                        last_time_next = item.now_ms;
                        change_next    = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg    <= 1'b0;
            raw_reg       <= 1'b0;
            last_time_reg <= '0;
        end
        else if (step)
        begin
            stable_reg    <= stable_next;
            raw_reg       <= raw_next;
            last_time_reg <= last_time_next;
        end
    end

    assign result.level   = stable_next;
    assign result.changed = change_next;
    assign result.rising  = stable_next & change_next;
    assign result.falling = ~stable_next & change_next;

endmodule

>>> sv/switch_debouncer_three_mode.sv
// Top level of the three-mode switch debouncer: input and result registers.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | to block  | in_valid / in_stall  | opcode, port_sample, now_ms
//  out     | from block| out_valid / out_stall| level, changed, rising, falling
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle sustained while out is not stalled; an input
// transaction passes through the input register, then the result register.
// The debounce state is updated as an item moves from the input register into
// the result register, so consecutive items see each other's effects.
// Stall on out holds the result; in_stall rises only while both registers are full.
// Reset clears the state and loads interval 10 ms, stable mode, pin 0.
module switch_debouncer_three_mode
    import sdtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [SAMPLE_W-1:0]   port_sample,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  level,
    output logic                  changed,
    output logic                  rising,
    output logic                  falling,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;

    sdtm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the held item forward when the result slot is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    sdtm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (~out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode      <= opcode;
            item_reg.port_sample <= port_sample;
            item_reg.now_ms      <= now_ms;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = result_reg.level;
    assign changed   = result_reg.changed;
    assign rising    = result_reg.rising;
    assign falling   = result_reg.falling;

endmodule
